@@ rtl/llbc_pkg.sv @@
// shared types and constants of the lamp brightness controller
package llbc_pkg;

    // widths of the item fields
    localparam int LEVEL_W  = 7;
    localparam int MINUTE_W = 11;
    localparam int TEMP_W   = 12;
    localparam int LIGHT_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // light quotient divider
    localparam int QUO_W     = 15;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [QUO_W-1:0] LIGHT_SCALE = 15'd20470;
    localparam logic [QUO_W-1:0] QUO_LOW     = 15'd3;

    // level and clock limits
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 7'd100;
    localparam logic [LEVEL_W-1:0]  RAMP_FLOOR  = 7'd5;
    localparam logic [LEVEL_W-1:0]  LEVEL_DIM   = 7'd10;
    localparam logic [LEVEL_W-1:0]  LEVEL_HALF  = 7'd50;
    localparam logic [LEVEL_W-1:0]  LEVEL_FULL  = 7'd99;
    localparam logic [MINUTE_W-1:0] LAST_MINUTE = 11'd1439;

    // register reset values
    localparam logic [LEVEL_W-1:0]  PEAK_RST    = 7'd100;
    localparam logic [MINUTE_W-1:0] MORNING_RST = 11'd480;
    localparam logic [MINUTE_W-1:0] MIDDAY_RST  = 11'd720;
    localparam logic [MINUTE_W-1:0] EVENING_RST = 11'd1080;
    localparam logic [MINUTE_W-1:0] NIGHT_RST   = 11'd1260;
    localparam logic [TEMP_W-1:0]   OTL_RST     = 12'd200;

    typedef enum logic [1:0] {
        CMD_STEP  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_SET   = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_NATURAL   = 2'd0,
        MODE_RAMP      = 2'd1,
        MODE_CIRCADIAN = 2'd2,
        MODE_MANUAL    = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_PEAK    = 3'd1,
        CFG_MORNING = 3'd2,
        CFG_MIDDAY  = 3'd3,
        CFG_EVENING = 3'd4,
        CFG_NIGHT   = 3'd5,
        CFG_OTL     = 3'd6
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic update;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

@@ rtl/llbc_ctrl.sv @@
// controller state machine: request handshake, divider sequencing, result handoff
module llbc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  llbc_pkg::t_dp_stat  i_stat,
    output llbc_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                             r_state, n_state;
    logic [llbc_pkg::DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic                               r_out_valid, n_out_valid;
    logic                               accept;
    logic                               out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_out_valid     = r_out_valid && !i_out_ready;
        o_cmd.load      = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.update    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_stat.need_div ? S_DIV : S_UPD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == llbc_pkg::DIV_CNT_W'(llbc_pkg::DIV_STEPS - 1)) begin
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // the divider runs its full step count before the update
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == llbc_pkg::DIV_CNT_W'(llbc_pkg::DIV_STEPS - 1))
        |=> (r_state == S_UPD))
        else $error("divider did not hand over to update");

    // a request always leads into processing
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DIV || r_state == S_UPD))
        else $error("request dropped after load");

    // a result only appears from an update
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.update))
        else $error("result valid without update");

endmodule

@@ rtl/llbc_datapath.sv @@
// datapath: configuration, lamp state, light divider and result register
module llbc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  llbc_pkg::t_dp_cmd                   i_cmd,
    output llbc_pkg::t_dp_stat                  o_stat,
    input  logic                                i_cfg_we,
    input  logic [llbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [llbc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [1:0]                          i_item_cmd,
    input  logic [llbc_pkg::TEMP_W-1:0]         i_temperature,
    input  logic [llbc_pkg::LIGHT_W-1:0]        i_light_sample,
    input  logic [llbc_pkg::MINUTE_W-1:0]       i_time_value,
    input  logic [1:0]                          i_channel,
    input  logic [llbc_pkg::LEVEL_W-1:0]        i_level,
    output logic [llbc_pkg::LEVEL_W-1:0]        o_red_level,
    output logic [llbc_pkg::LEVEL_W-1:0]        o_green_level,
    output logic [llbc_pkg::LEVEL_W-1:0]        o_blue_level,
    output logic                                o_overheat,
    output logic [llbc_pkg::MINUTE_W-1:0]       o_minute_now
);

    localparam int LW = llbc_pkg::LEVEL_W;
    localparam int MW = llbc_pkg::MINUTE_W;
    localparam int QW = llbc_pkg::QUO_W;
    localparam int DW = llbc_pkg::LIGHT_W;

    // configuration registers
    llbc_pkg::t_mode                r_mode;
    logic [LW-1:0]                  r_peak;
    logic [MW-1:0]                  r_morning, r_midday, r_evening, r_night;
    logic [llbc_pkg::TEMP_W-1:0]    r_otl;

    // captured request
    llbc_pkg::t_cmd                 r_cmd;
    logic [llbc_pkg::TEMP_W-1:0]    r_temp;
    logic [DW-1:0]                  r_light;
    logic [MW-1:0]                  r_tval;
    logic [1:0]                     r_chan;
    logic [LW-1:0]                  r_lvl;

    // lamp state
    logic [LW-1:0]                  r_level [3];
    logic [LW-1:0]                  n_level [3];
    logic [2:0]                     r_rising, n_rising;
    logic                           r_hot, n_hot;
    logic [MW-1:0]                  r_minute, n_minute;

    // divider
    logic [DW-1:0]                  r_rem;
    logic [QW-1:0]                  r_quo;
    logic [DW:0]                    div_shift;
    logic                           div_ge;

    // result register
    logic [LW-1:0]                  r_o_red, r_o_green, r_o_blue;
    logic                           r_o_hot;
    logic [MW-1:0]                  r_o_minute;

    logic [LW-1:0]                  peak;
    logic [LW-1:0]                  ramp_level [3];
    logic [2:0]                     ramp_rising;
    logic [LW-1:0]                  nat_level;
    logic [LW-1:0]                  circ_level;
    logic [LW-1:0]                  man_level;
    logic                           hot_now;

    // divider need is decided on the live request fields
    assign o_stat.need_div = (llbc_pkg::t_cmd'(i_item_cmd) == llbc_pkg::CMD_STEP)
                             && !(i_temperature > r_otl)
                             && (r_mode == llbc_pkg::MODE_NATURAL)
                             && (i_light_sample != '0);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= llbc_pkg::MODE_NATURAL;
            r_peak    <= llbc_pkg::PEAK_RST;
            r_morning <= llbc_pkg::MORNING_RST;
            r_midday  <= llbc_pkg::MIDDAY_RST;
            r_evening <= llbc_pkg::EVENING_RST;
            r_night   <= llbc_pkg::NIGHT_RST;
            r_otl     <= llbc_pkg::OTL_RST;
        end else if (i_cfg_we) begin
            case (llbc_pkg::t_cfg_idx'(i_cfg_index))
                llbc_pkg::CFG_MODE:    r_mode    <= llbc_pkg::t_mode'(i_cfg_data[1:0]);
                llbc_pkg::CFG_PEAK:    r_peak    <= i_cfg_data[LW-1:0];
                llbc_pkg::CFG_MORNING: r_morning <= i_cfg_data[MW-1:0];
                llbc_pkg::CFG_MIDDAY:  r_midday  <= i_cfg_data[MW-1:0];
                llbc_pkg::CFG_EVENING: r_evening <= i_cfg_data[MW-1:0];
                llbc_pkg::CFG_NIGHT:   r_night   <= i_cfg_data[MW-1:0];
                llbc_pkg::CFG_OTL:     r_otl     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= llbc_pkg::t_cmd'(i_item_cmd);
            r_temp  <= i_temperature;
            r_light <= i_light_sample;
            r_tval  <= i_time_value;
            r_chan  <= i_channel;
            r_lvl   <= i_level;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign div_shift = {r_rem, r_quo[QW-1]};
    assign div_ge    = (div_shift >= {1'b0, r_light});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_quo <= llbc_pkg::LIGHT_SCALE;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? DW'(div_shift - {1'b0, r_light}) : div_shift[DW-1:0];
            r_quo <= {r_quo[QW-2:0], div_ge};
        end
    end

    // natural level from the quotient
    always_comb begin
        if (r_light == '0 || r_quo <= llbc_pkg::QUO_LOW
                || r_quo > QW'(llbc_pkg::LEVEL_MAX)) begin
            nat_level = llbc_pkg::LEVEL_MAX;
        end else begin
            nat_level = r_quo[LW-1:0];
        end
    end

    // triangle ramp, one step per channel
    assign peak = (r_peak > llbc_pkg::LEVEL_MAX) ? llbc_pkg::LEVEL_MAX : r_peak;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ramp_level[i]  = r_level[i];
            ramp_rising[i] = r_rising[i];
            if (r_rising[i]) begin
                if (r_level[i] >= peak) begin
                    ramp_rising[i] = 1'b0;
                end else begin
                    ramp_level[i] = r_level[i] + 1'b1;
                end
            end else begin
                if (r_level[i] <= llbc_pkg::RAMP_FLOOR) begin
                    ramp_rising[i] = 1'b1;
                end else begin
                    ramp_level[i] = r_level[i] - 1'b1;
                end
            end
        end
    end

    // circadian schedule
    always_comb begin
        if (r_minute < r_morning) begin
            circ_level = llbc_pkg::LEVEL_DIM;
        end else if (r_minute < r_midday) begin
            circ_level = llbc_pkg::LEVEL_HALF;
        end else if (r_minute < r_evening) begin
            circ_level = llbc_pkg::LEVEL_FULL;
        end else if (r_minute < r_night) begin
            circ_level = llbc_pkg::LEVEL_HALF;
        end else begin
            circ_level = llbc_pkg::LEVEL_DIM;
        end
    end

    assign man_level = (r_lvl > llbc_pkg::LEVEL_MAX) ? llbc_pkg::LEVEL_MAX : r_lvl;
    assign hot_now   = (r_temp > r_otl);

    // next lamp state
    always_comb begin
        n_level  = r_level;
        n_rising = r_rising;
        n_hot    = r_hot;
        n_minute = r_minute;
        case (r_cmd)
            llbc_pkg::CMD_STEP: begin
                n_hot = hot_now;
                if (hot_now || r_mode == llbc_pkg::MODE_RAMP) begin
                    n_level  = ramp_level;
                    n_rising = ramp_rising;
                end else if (r_mode == llbc_pkg::MODE_NATURAL) begin
                    for (int i = 0; i < 3; i++) n_level[i] = nat_level;
                end else if (r_mode == llbc_pkg::MODE_CIRCADIAN) begin
                    for (int i = 0; i < 3; i++) n_level[i] = circ_level;
                end
            end
            llbc_pkg::CMD_TICK: begin
                n_minute = (r_minute >= llbc_pkg::LAST_MINUTE) ? '0 : r_minute + 1'b1;
            end
            llbc_pkg::CMD_SET: begin
                n_minute = (r_tval > llbc_pkg::LAST_MINUTE) ? llbc_pkg::LAST_MINUTE : r_tval;
            end
            llbc_pkg::CMD_WRITE: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_chan == 2'(i)) n_level[i] = man_level;
                end
            end
            default: begin
            end
        endcase
    end

    // lamp state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_level[i] <= llbc_pkg::LEVEL_FULL;
            r_rising <= 3'b111;
            r_hot    <= 1'b0;
            r_minute <= '0;
        end else if (i_cmd.update) begin
            r_level  <= n_level;
            r_rising <= n_rising;
            r_hot    <= n_hot;
            r_minute <= n_minute;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_o_red    <= n_level[0];
            r_o_green  <= n_level[1];
            r_o_blue   <= n_level[2];
            r_o_hot    <= n_hot;
            r_o_minute <= n_minute;
        end
    end

    assign o_red_level   = r_o_red;
    assign o_green_level = r_o_green;
    assign o_blue_level  = r_o_blue;
    assign o_overheat    = r_o_hot;
    assign o_minute_now  = r_o_minute;

endmodule

@@ rtl/led_lamp_brightness_controller.sv @@
// top level of the lamp brightness controller
// Usage:
// - request channel (i_in_valid / o_in_ready) carries one item: a control step
//   with temperature and light samples, a minute tick, a time set, or a manual
//   write of one channel level
// - result channel (o_out_valid / i_out_ready) returns one result per request:
//   the three channel levels, the overheat flag and the minute of day
// - config channel (i_cfg_valid / o_cfg_ready) writes one register per request
//   by index; it is always ready; write it only while the block is idle (unchecked)
// Flow:
// - a control step in natural mode with a nonzero light sample and a
//   temperature not above the limit runs the bit-serial light divider; the
//   update then writes the result, and only then is the next request taken
// - every other request goes from acceptance straight to the update, which
//   writes the result; no new request is taken before that update
// - the result sits in an output register; while the receiver stalls the
//   next request is still taken and worked on, and it waits for the register
// Reset: synchronous active low; levels go to 99, ramps rising, clock at
//   minute 0, overheat clear, registers to their defaults, no result pending
module led_lamp_brightness_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_cmd,
    input  logic [llbc_pkg::TEMP_W-1:0]         i_temperature,
    input  logic [llbc_pkg::LIGHT_W-1:0]        i_light_sample,
    input  logic [llbc_pkg::MINUTE_W-1:0]       i_time_value,
    input  logic [1:0]                          i_channel,
    input  logic [llbc_pkg::LEVEL_W-1:0]        i_level,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [llbc_pkg::LEVEL_W-1:0]        o_red_level,
    output logic [llbc_pkg::LEVEL_W-1:0]        o_green_level,
    output logic [llbc_pkg::LEVEL_W-1:0]        o_blue_level,
    output logic                                o_overheat,
    output logic [llbc_pkg::MINUTE_W-1:0]       o_minute_now,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [llbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [llbc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    llbc_pkg::t_dp_cmd  dp_cmd;
    llbc_pkg::t_dp_stat dp_stat;

    // config port takes a request every cycle
    assign o_cfg_ready = 1'b1;

    llbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    llbc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_item_cmd     (i_cmd),
        .i_temperature  (i_temperature),
        .i_light_sample (i_light_sample),
        .i_time_value   (i_time_value),
        .i_channel      (i_channel),
        .i_level        (i_level),
        .o_red_level    (o_red_level),
        .o_green_level  (o_green_level),
        .o_blue_level   (o_blue_level),
        .o_overheat     (o_overheat),
        .o_minute_now   (o_minute_now)
    );

endmodule
